// File: design/bffa_pkg.sv
`default_nettype none
package bffa_pkg;

	localparam int BASE_W     = 32;
	localparam int FRAMES_W   = 21;
	localparam int BYTES_W    = 32;
	localparam int ADDR_W     = 32;
	localparam int PHYS_W     = 33;
	// bump offset is kept as a two's complement value, a rewind can go below base
	localparam int BUMP_W     = 34;
	localparam int LIM_W      = 33;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [FRAMES_W-1:0] HEAP_FRAMES_RESET = 21'd256;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_FRAMES  = 1'd1;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_NO_MEMORY    = 2'd1;
	localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;
	localparam logic [1:0] ST_NO_BLOCK     = 2'd3;

	typedef struct packed {
		logic               action;
		logic [BYTES_W-1:0] request_bytes;
		logic [ADDR_W-1:0]  release_address;
	} bffa_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] data_address;
	} bffa_rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  data_address;
		logic [BYTES_W-1:0] data_bytes;
		logic               is_free;
	} bffa_entry_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_PREP,
		BS_LIMIT,
		BS_DECIDE,
		BS_SCAN
	} bffa_state_t;

endpackage
`default_nettype wire

// File: design/bffa_ram.sv
`default_nettype none
module bffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: design/bump_first_fit_block_allocator_unit.sv
`default_nettype none
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// request   | start, busy          | request (action, request_bytes, release_address)
// result    | done (one-cycle)     | result (status, data_address)
// config    | cfg_we, cfg_index    | cfg_wdata (base_address, heap_frames)
//
// one request at a time; busy is high from the transfer until the result is out
// bump allocate or range/empty fail: decided in the decide state after prep and limit
// table scan (first-fit reuse, free lookup): after the decide state, reads up to the
// entry count (at most MAX_BLOCKS) of table entries, one entry per cycle, through
// the single read port of the table ram
// reset clears the table count and bump offset; no clearing pass is needed
// done is high for exactly one cycle and cannot be stalled; a new request may
// be taken in that same cycle
module bump_first_fit_block_allocator_unit #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 20,
	parameter int FRAME_BYTES  = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  bffa_pkg::bffa_req_t                  request,
	output logic                                 done,
	output bffa_pkg::bffa_rsp_t                  result,
	input  logic                                 cfg_we,
	input  logic [bffa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bffa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import bffa_pkg::*;

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int FB_W  = $clog2(FRAME_BYTES + 1);
	localparam int HB_W  = FRAMES_W + FB_W;
	localparam int LW    = (HB_W > LIM_W) ? HB_W : LIM_W;
	localparam int ENT_W = $bits(bffa_entry_t);

	bffa_state_t state_q, state_d;

	logic [BASE_W-1:0]   base_q;
	logic [FRAMES_W-1:0] frames_q;
	bffa_req_t           req_q;

	logic [HB_W-1:0]     heap_bytes_q;
	logic [LIM_W-1:0]    space_q;
	logic [PHYS_W-1:0]   phys_q;
	logic [LIM_W-1:0]    lim_q;
	logic [BUMP_W:0]     sum_q;
	logic                out_range_q;

	logic [CNT_W-1:0]    count_q;
	logic [BUMP_W-1:0]   bump_q;

	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    left_q;
	logic                chk_s1;
	logic [IDX_W-1:0]    chk_idx_s1;
	logic                last_s1;

	logic                done_q;
	bffa_rsp_t           result_q;

	// combinational controls
	logic                fin;
	bffa_rsp_t           fin_rsp;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	bffa_entry_t         mem_wdata;
	logic                rd_en;
	logic [ENT_W-1:0]    rd_word;
	bffa_entry_t         rd_ent;
	logic                scan_start;
	logic                cnt_inc;
	logic                cnt_dec;
	logic                bump_ld;
	logic [BUMP_W-1:0]   bump_d;

	logic [CNT_W-1:0]    cnt_m1;
	logic                fit;
	logic                hit;
	logic [LW-1:0]       heap_ext;
	logic [LW-1:0]       space_ext;
	logic [LW:0]         rng_end;
	logic [ADDR_W-1:0]   bump_addr;
	logic [BUMP_W-1:0]   rewind;

	assign cnt_m1    = count_q - 1'b1;
	assign fit       = (count_q < CNT_W'(MAX_BLOCKS)) && !sum_q[BUMP_W]
		&& (sum_q[BUMP_W-1:0] <= {1'b0, lim_q});
	assign heap_ext  = LW'(heap_bytes_q);
	assign space_ext = LW'(space_q);
	assign rng_end   = (LW+1)'(base_q) + (LW+1)'(heap_bytes_q);
	assign bump_addr = base_q + bump_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
	assign rewind    = {2'b00, req_q.release_address} - BUMP_W'(HEADER_BYTES)
		- {2'b00, base_q};

	assign rd_ent = bffa_entry_t'(rd_word);
	assign hit = (req_q.action == ACT_ALLOC)
		? (rd_ent.is_free && (rd_ent.data_bytes >= req_q.request_bytes))
		: (rd_ent.data_address == req_q.release_address);

	bffa_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(ENT_W'(mem_wdata)),
		.re   (rd_en),
		.raddr(idx_q),
		.rdata(rd_word)
	);

	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_rsp    = '{status: ST_OK, data_address: '0};
		mem_we     = 1'b0;
		mem_waddr  = count_q[IDX_W-1:0];
		mem_wdata  = '{data_address: bump_addr, data_bytes: req_q.request_bytes,
			is_free: 1'b0};
		rd_en      = 1'b0;
		scan_start = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		bump_ld    = 1'b0;
		bump_d     = sum_q[BUMP_W-1:0];
		case (state_q)
			BS_IDLE: begin
				if (start) begin
					state_d = BS_PREP;
				end
			end
			BS_PREP: begin
				state_d = BS_LIMIT;
			end
			BS_LIMIT: begin
				state_d = BS_DECIDE;
			end
			BS_DECIDE: begin
				if (req_q.action == ACT_ALLOC) begin
					if (fit) begin
						mem_we  = 1'b1;
						cnt_inc = 1'b1;
						bump_ld = 1'b1;
						fin     = 1'b1;
						fin_rsp = '{status: ST_OK, data_address: bump_addr};
					end else if (count_q == '0) begin
						fin     = 1'b1;
						fin_rsp = '{status: ST_NO_MEMORY, data_address: '0};
					end else begin
						scan_start = 1'b1;
					end
				end else begin
					if (out_range_q) begin
						fin     = 1'b1;
						fin_rsp = '{status: ST_OUT_OF_RANGE, data_address: '0};
					end else if (count_q == '0) begin
						fin     = 1'b1;
						fin_rsp = '{status: ST_NO_BLOCK, data_address: '0};
					end else begin
						scan_start = 1'b1;
					end
				end
				state_d = fin ? BS_IDLE : BS_SCAN;
			end
			BS_SCAN: begin
				rd_en     = (left_q != '0);
				mem_waddr = chk_idx_s1;
				mem_wdata = '{data_address: rd_ent.data_address,
					data_bytes: rd_ent.data_bytes,
					is_free: (req_q.action == ACT_FREE)};
				bump_d    = rewind;
				if (chk_s1 && hit) begin
					fin = 1'b1;
					if (req_q.action == ACT_ALLOC) begin
						mem_we  = 1'b1;
						fin_rsp = '{status: ST_OK, data_address: rd_ent.data_address};
					end else if (chk_idx_s1 == cnt_m1[IDX_W-1:0]) begin
						// newest block: pop it and rewind the bump offset
						cnt_dec = 1'b1;
						bump_ld = 1'b1;
					end else begin
						mem_we = 1'b1;
					end
				end else if (chk_s1 && last_s1) begin
					fin     = 1'b1;
					fin_rsp = '{status: (req_q.action == ACT_ALLOC) ? ST_NO_MEMORY
						: ST_NO_BLOCK, data_address: '0};
				end
				if (fin) begin
					rd_en   = 1'b0;
					state_d = BS_IDLE;
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BS_IDLE;
			base_q   <= '0;
			frames_q <= HEAP_FRAMES_RESET;
			count_q  <= '0;
			bump_q   <= '0;
			left_q   <= '0;
			chk_s1   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE_ADDRESS: base_q <= cfg_wdata[BASE_W-1:0];
					CFG_HEAP_FRAMES:  frames_q <= cfg_wdata[FRAMES_W-1:0];
					default: ;
				endcase
			end
			if (cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cnt_dec) begin
				count_q <= cnt_m1;
			end
			if (bump_ld) begin
				bump_q <= bump_d;
			end
			if (scan_start) begin
				left_q <= count_q;
			end else if (rd_en) begin
				left_q <= left_q - 1'b1;
			end
			chk_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BS_IDLE && start) begin
			req_q <= request;
		end
		heap_bytes_q <= HB_W'(frames_q) * HB_W'(FRAME_BYTES);
		space_q      <= 33'h1_0000_0000 - {1'b0, base_q};
		phys_q       <= {1'b0, req_q.request_bytes} + PHYS_W'(HEADER_BYTES);
		lim_q        <= (heap_ext < space_ext) ? heap_bytes_q[LIM_W-1:0] : space_q;
		sum_q        <= {bump_q[BUMP_W-1], bump_q} + {2'b00, phys_q};
		out_range_q  <= (req_q.release_address < base_q)
			|| ((LW+1)'(req_q.release_address) > rng_end);
		if (scan_start) begin
			idx_q <= (req_q.action == ACT_ALLOC) ? '0 : cnt_m1[IDX_W-1:0];
		end else if (rd_en) begin
			idx_q <= (req_q.action == ACT_ALLOC) ? idx_q + 1'b1 : idx_q - 1'b1;
		end
		chk_idx_s1 <= idx_q;
		last_s1    <= (left_q == CNT_W'(1));
		if (fin) begin
			result_q <= fin_rsp;
		end
	end

	assign busy   = (state_q != BS_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCKS))
		else $error("block table count above capacity");
	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (CNT_W'(idx_q) < count_q))
		else $error("scan read beyond the table fill");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request transfer did not start work");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (busy && !done))
		else $error("table write outside a request");
`endif

endmodule
`default_nettype wire
